// ===== src/mbc_pkg.sv =====
// mbc_pkg: shared types and constants for the minimum bill count block.
// No dependencies; used by every module under src.
package mbc_pkg;

   localparam int unsigned VAL_W       = 12;  // amount, denomination and count width
   localparam int unsigned NUM_REGS    = 6;   // denomination registers
   localparam int unsigned DENOM_SLOTS = 8;   // slots scanned by the sequencer
   localparam int unsigned SLOT_W      = 3;   // index width for DENOM_SLOTS
   localparam int unsigned CSR_IDX_W   = 3;   // register index width

   typedef logic [VAL_W-1:0] val_type;

   localparam val_type DENOM_RESET [NUM_REGS] = '{
      val_type'(500), val_type'(200), val_type'(100),
      val_type'(50),  val_type'(20),  val_type'(10)
   };

   // One table entry: valid mark and best count.
   typedef struct packed {
      logic    valid;
      val_type count;
   } entry_type;

   // Running minimum for the table entry being built.
   typedef struct packed {
      logic    found;
      val_type best;
   } acc_type;

endpackage

// ===== src/min_bill_count_change.sv =====
// min_bill_count_change: fewest bills from the configured denominations for an amount.
// Zero and out-of-range amounts skip the table build; every result waits for the response
// register to free up.
// One transaction at a time. The rate is set by the slot scan over the single table read port.
// Reset (synchronous, active high) clears the sequencer and result valid and restores the
// denominations to 500/200/100/50/20/10. The table needs no clearing: it is rebuilt from
// entry 0 for every transaction before any entry is read.
// Depends on mbc_pkg, mbc_table and mbc_min_unit.
module min_bill_count_change #(
   parameter int unsigned MAX_AMOUNT = 4095,
   parameter int unsigned NUM_DENOMS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mbc_pkg::VAL_W-1:0]           req_amount,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mbc_pkg::VAL_W-1:0]           rsp_bill_count,
   output logic                                rsp_reachable,
   // configuration writes
   input  logic                                csr_we,
   input  logic [mbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mbc_pkg::VAL_W-1:0]           csr_wdata
);

   localparam int unsigned DEPTH  = MAX_AMOUNT + 1;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   // common width for comparing table addresses against 12-bit values
   localparam int unsigned CMP_W  = (ADDR_W > mbc_pkg::VAL_W) ? ADDR_W : mbc_pkg::VAL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_EVAL,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // ---------------------------------------------------------------------
   // Denomination registers
   // ---------------------------------------------------------------------
   mbc_pkg::val_type denom_ff [mbc_pkg::NUM_REGS];
   mbc_pkg::val_type slot     [mbc_pkg::DENOM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mbc_pkg::NUM_REGS; i++) begin
            denom_ff[i] <= mbc_pkg::DENOM_RESET[i];
         end
      end else if (csr_we) begin
         // indices beyond the register list are dropped
         for (int i = 0; i < mbc_pkg::NUM_REGS; i++) begin
            if (csr_index == mbc_pkg::CSR_IDX_W'(i)) begin
               denom_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // Scan slots: registers that are not fitted or not used read as zero
   // and so never take part.
   always_comb begin
      for (int i = 0; i < mbc_pkg::DENOM_SLOTS; i++) begin
         if (i < mbc_pkg::NUM_REGS && i < NUM_DENOMS) begin
            slot[i] = denom_ff[i];
         end else begin
            slot[i] = '0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer state
   // ---------------------------------------------------------------------
   state_type                     state_ff,  state_in;
   logic [ADDR_W-1:0]             v_ff,      v_in;       // table entry being built
   logic [mbc_pkg::SLOT_W-1:0]    k_ff,      k_in;       // denomination slot
   mbc_pkg::val_type              amount_ff, amount_in;
   mbc_pkg::acc_type              acc_ff,    acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mbc_pkg::val_type              rsp_count_ff, rsp_count_in;
   logic                          rsp_reach_ff, rsp_reach_in;

   // table port
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   mbc_pkg::entry_type            wr_data;
   logic                          rd_en;
   logic [ADDR_W-1:0]             rd_addr;
   mbc_pkg::entry_type            rd_data;

   mbc_pkg::acc_type              acc_min;
   mbc_pkg::val_type              denom;
   logic                          denom_ok;
   logic                          last_slot;
   logic                          last_entry;
   logic                          over_range;

   assign denom      = slot[k_ff];
   assign denom_ok   = (denom != '0) && (CMP_W'(denom) <= CMP_W'(v_ff));
   assign last_slot  = (k_ff == mbc_pkg::SLOT_W'(NUM_DENOMS - 1));
   assign last_entry = (CMP_W'(v_ff) == CMP_W'(amount_ff));
   assign over_range = (CMP_W'(req_amount) > CMP_W'(MAX_AMOUNT));
   assign rd_addr    = ADDR_W'(CMP_W'(v_ff) - CMP_W'(denom));

   mbc_table #(
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mbc_min_unit u_min (
      .prev    (rd_data),
      .acc_cur (acc_ff),
      .acc_nxt (acc_min)
   );

   // ISSUE reads table[v - d] for a usable slot, EVAL folds it into the
   // minimum, WRITE stores the finished entry and steps v.
   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      amount_in    = amount_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_count_in = rsp_count_ff;
      rsp_reach_in = rsp_reach_ff;
      wr_en        = 1'b0;
      wr_addr      = v_ff;
      wr_data      = '{valid: acc_ff.found,
                       count: acc_ff.found ? acc_ff.best : '0};
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               amount_in = req_amount;
               if (over_range) begin
                  acc_in   = '0;
                  state_in = ST_FINISH;
               end else if (req_amount == '0) begin
                  // zero needs zero bills
                  acc_in   = '{found: 1'b1, best: '0};
                  state_in = ST_FINISH;
               end else begin
                  // seed entry 0, then build from 1 upwards
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = '{valid: 1'b1, count: '0};
                  v_in     = ADDR_W'(1);
                  k_in     = '0;
                  acc_in   = '0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (denom_ok) begin
               rd_en    = 1'b1;
               state_in = ST_EVAL;
            end else if (last_slot) begin
               state_in = ST_WRITE;
            end else begin
               k_in = k_ff + mbc_pkg::SLOT_W'(1);
            end
         end
         ST_EVAL: begin
            acc_in = acc_min;
            if (last_slot) begin
               state_in = ST_WRITE;
            end else begin
               k_in     = k_ff + mbc_pkg::SLOT_W'(1);
               state_in = ST_ISSUE;
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
            if (last_entry) begin
               state_in = ST_FINISH;
            end else begin
               v_in     = v_ff + ADDR_W'(1);
               k_in     = '0;
               acc_in   = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff.found ? acc_ff.best : '0;
               rsp_reach_in = acc_ff.found;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      k_ff         <= k_in;
      amount_ff    <= amount_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
      rsp_reach_ff <= rsp_reach_in;
   end

   // A finished transaction can sit in the output register while the
   // next request is taken.
   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bill_count = rsp_count_ff;
   assign rsp_reachable  = rsp_reach_ff;

endmodule

// ===== src/mbc_table.sv =====
// mbc_table: best-count table, one write port and one registered read port.
// Depends on mbc_pkg for the entry type.
module mbc_table #(
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DEPTH  = 4096
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  mbc_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output mbc_pkg::entry_type  rd_data
);

   mbc_pkg::entry_type mem_ff [DEPTH];
   mbc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mbc_min_unit.sv =====
// mbc_min_unit: shared add-one and compare unit that folds one candidate
// table entry into the running minimum. Depends on mbc_pkg.
module mbc_min_unit (
   input  mbc_pkg::entry_type prev,
   input  mbc_pkg::acc_type   acc_cur,
   output mbc_pkg::acc_type   acc_nxt
);

   mbc_pkg::val_type cand;

   assign cand = prev.count + mbc_pkg::val_type'(1);

   always_comb begin
      acc_nxt = acc_cur;
      if (prev.valid && (!acc_cur.found || cand < acc_cur.best)) begin
         acc_nxt.found = 1'b1;
         acc_nxt.best  = cand;
      end
   end

endmodule
